>>> rtl/core/rpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpd_pkg;

   // command codes
   localparam logic [2:0] CMD_FILL = 3'd0;
   localparam logic [2:0] CMD_RECT = 3'd1;
   localparam logic [2:0] CMD_DISC = 3'd2;
   localparam logic [2:0] CMD_LINE = 3'd3;
   localparam logic [2:0] CMD_READ = 3'd4;

   // register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 4'd1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_DATA_W-1:0] CSR_SIZE_RESET = 9'd256;

   // internal widths
   localparam int FLD_W  = 12;   // width of coordinate fields
   localparam int CRD_W  = 16;   // clipped box coordinates and multiplier operands
   localparam int PROD_W = 32;   // multiplier product, divider dividend
   localparam int DEN_W  = 16;   // divider divisor
   localparam int LY_W   = 28;   // unclipped line rows
   localparam int SQ_W   = 25;   // squared distances

   typedef struct packed {
      logic [2:0]              command;
      logic signed [FLD_W-1:0] point_x;
      logic signed [FLD_W-1:0] point_y;
      logic signed [FLD_W-1:0] end_x;
      logic signed [FLD_W-1:0] end_y;
      logic [FLD_W-1:0]        rect_width;
      logic [FLD_W-1:0]        rect_height;
      logic signed [FLD_W-1:0] radius;
      logic [23:0]             color;
   } req_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic       is_read_data;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/rpd_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rpd_div
   import rpd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [PROD_W-1:0] dividend,
   input  wire logic signed [DEN_W-1:0]  divisor,
   output logic                          done,
   output logic signed [PROD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0] quo_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [DEN_W:0]    shift_rem;
   logic              fits;

   // one quotient bit per cycle
   assign shift_rem = {rem_ff, quo_ff[PROD_W-1]};
   assign fits      = shift_rem >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
            den_ff <= divisor[DEN_W-1] ? DEN_W'(-divisor) : DEN_W'(divisor);
            neg_ff <= dividend[PROD_W-1] ^ divisor[DEN_W-1];
            rem_ff <= '0;
            cnt_ff <= CNT_W'(PROD_W);
         end else if (cnt_ff != '0) begin
            rem_ff <= fits ? DEN_W'(shift_rem - {1'b0, den_ff}) : DEN_W'(shift_rem);
            quo_ff <= {quo_ff[PROD_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // truncate toward zero: divide magnitudes, then apply the sign
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

`default_nettype wire

>>> rtl/core/raster_primitive_drawer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Framebuffer drawing engine with one single-port frame memory of 24-bit pixels.
// Command channel: a beat is taken when start is high and busy is low; busy
// stays high until the result beat has been shown. Each command gives exactly
// one result beat on rsp_data, marked by rsp_strobe for one cycle; the
// receiver has no way to stall it.
// Register channel: csr_ready is always high; write only while busy is low.
// One frame memory port; the drawing walks step one pixel per cycle:
//   fill:      multiply width by height, then write every pixel in address order
//   rectangle: clip the box, then write it row by row; disc: also square the
//              radius and the first offsets, and write only covered pixels
//   line:      divide once for the offset and once per clipped column edge,
//              then write each column's span; vertical line: one span only
//   read:      address multiply, registered memory read, then the result
//   other codes: all-zero result
// Reset sets both canvas sizes to 256 and idles the engine; frame memory is
// not cleared, so every pixel must be drawn before it is read back.
module raster_primitive_drawer_top
   import rpd_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_FILL_N, ST_FILL, ST_BOX_CHK, ST_BOX_R2, ST_BOX_DX,
      ST_BOX_DY, ST_BOX_ADDR, ST_BOX, ST_LINE_M0, ST_LINE_D0, ST_LINE_MA,
      ST_LINE_DA, ST_LINE_MB, ST_LINE_DB, ST_LINE_NEXT, ST_SPAN_CLIP,
      ST_SPAN_ADDR, ST_SPAN, ST_READ_ADDR, ST_READ_MEM, ST_READ_DATA, ST_DONE
   } state_type;

   state_type state_ff;

   logic [CSR_DATA_W-1:0]   cw_ff, ch_ff;
   logic [2:0]              cmd_ff;
   logic signed [CRD_W-1:0] px_ff, py_ff, ex_ff, ey_ff, rad_ff;
   logic [FLD_W-1:0]        rw_ff, rh_ff;
   logic [23:0]             color_ff;
   logic signed [CRD_W-1:0] bx_lo_ff, bx_hi_ff, by_lo_ff, by_hi_ff;
   logic signed [CRD_W-1:0] x_ff, y_ff, sp_x_ff;
   logic signed [CRD_W-1:0] dx_ff, dy_ff, ldx_ff, ldy_ff;
   logic [SQ_W-1:0]         r2_ff, dx2_ff, dxs2_ff, dy2_ff;
   logic [AW-1:0]           addr_ff, row_ff;
   logic [AW:0]             n_ff;
   logic                    disc_ff, sp_line_ff;
   logic signed [LY_W-1:0]  off_ff, qa_ff, ya_ff, yb_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                    div_start_ff;
   rsp_type                 rsp_ff;
   logic [23:0]             rdata_ff;
   logic [23:0]             frame_mem [DEPTH];

   logic [11:0]             ew, eh;
   logic signed [CRD_W-1:0] ew_s, eh_s;
   logic signed [CRD_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                    div_done;
   logic signed [PROD_W-1:0] div_q;
   logic signed [LY_W-1:0]  q_ly;
   logic                    covered, wr_en;
   logic signed [CRD_W-1:0] rect_xe, rect_ye, dsc_xl, dsc_xh, dsc_yl, dsc_yh;
   logic signed [CRD_W-1:0] ln_lo, ln_hi;
   logic signed [LY_W-1:0]  sp_lo, sp_hi;
   logic [SQ_W-1:0]         dx2_nx, dy2_nx;

   function automatic logic signed [CRD_W-1:0] smax(input logic signed [CRD_W-1:0] a,
                                                    input logic signed [CRD_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [CRD_W-1:0] smin(input logic signed [CRD_W-1:0] a,
                                                    input logic signed [CRD_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // effective canvas size
   assign ew   = (cw_ff > MAX_WIDTH) ? 12'(MAX_WIDTH) : 12'(cw_ff);
   assign eh   = (ch_ff > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : 12'(ch_ff);
   assign ew_s = $signed(CRD_W'(ew));
   assign eh_s = $signed(CRD_W'(eh));

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_strobe = state_ff == ST_DONE;
   assign rsp_data   = rsp_ff;

   // clip bounds straight from the latched command
   assign rect_xe = smin(px_ff + $signed(CRD_W'(rw_ff)), ew_s) - CRD_W'(1);
   assign rect_ye = smin(py_ff + $signed(CRD_W'(rh_ff)), eh_s) - CRD_W'(1);
   assign dsc_xl  = smax(px_ff - rad_ff, '0);
   assign dsc_xh  = smin(px_ff + rad_ff, ew_s - CRD_W'(1));
   assign dsc_yl  = smax(py_ff - rad_ff, '0);
   assign dsc_yh  = smin(py_ff + rad_ff, eh_s - CRD_W'(1));
   assign ln_lo   = smax(smin(px_ff, ex_ff), '0);
   assign ln_hi   = smin(smax(px_ff, ex_ff), ew_s - CRD_W'(1));

   // span row limits: the smaller and the larger of the two end rows
   assign sp_lo = (ya_ff < yb_ff) ? ya_ff : yb_ff;
   assign sp_hi = (ya_ff < yb_ff) ? yb_ff : ya_ff;

   // incremental squares: (d+1)^2 = d^2 + 2d + 1
   assign dx2_nx = SQ_W'($signed({2'b00, dx2_ff}) + $signed((SQ_W+2)'(dx_ff) <<< 1) + 1);
   assign dy2_nx = SQ_W'($signed({2'b00, dy2_ff}) + $signed((SQ_W+2)'(dy_ff) <<< 1) + 1);

   assign covered = !disc_ff || ((SQ_W+1)'(dx2_ff) + (SQ_W+1)'(dy2_ff) <= (SQ_W+1)'(r2_ff));
   assign wr_en  = ((state_ff == ST_FILL) && (n_ff != '0)) ||
                   ((state_ff == ST_BOX) && covered) || (state_ff == ST_SPAN);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_FILL_N:    begin mul_a = ew_s;     mul_b = eh_s;  end
         ST_BOX_R2:    begin mul_a = rad_ff;   mul_b = rad_ff; end
         ST_BOX_DX:    begin mul_a = dx_ff;    mul_b = dx_ff; end
         ST_BOX_DY:    begin mul_a = dy_ff;    mul_b = dy_ff; end
         ST_BOX_ADDR:  begin mul_a = by_lo_ff; mul_b = ew_s;  end
         ST_LINE_M0:   begin mul_a = ldy_ff;   mul_b = px_ff; end
         ST_LINE_MA:   begin mul_a = ldy_ff;   mul_b = x_ff;  end
         ST_LINE_MB:   begin mul_a = ldy_ff;   mul_b = x_ff + CRD_W'(1); end
         ST_SPAN_ADDR: begin mul_a = y_ff;     mul_b = ew_s;  end
         ST_READ_ADDR: begin mul_a = py_ff;    mul_b = ew_s;  end
         default:      begin mul_a = '0;       mul_b = '0;    end
      endcase
   end

   assign mul_p = PROD_W'(mul_a * mul_b);

   rpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff),
      .divisor  (DEN_W'(ldx_ff)),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_ly = LY_W'(div_q);

   // frame memory: one write (when enabled) and one registered read per cycle, both at addr_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[addr_ff] <= color_ff;
      end
      rdata_ff <= frame_mem[addr_ff];
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= CSR_SIZE_RESET;
         ch_ff <= CSR_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:  cw_ff <= csr_data;
            CSR_CANVAS_HEIGHT: ch_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // command sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_data.command;
                  px_ff    <= CRD_W'(req_data.point_x);
                  py_ff    <= CRD_W'(req_data.point_y);
                  ex_ff    <= CRD_W'(req_data.end_x);
                  ey_ff    <= CRD_W'(req_data.end_y);
                  rw_ff    <= req_data.rect_width;
                  rh_ff    <= req_data.rect_height;
                  rad_ff   <= CRD_W'(req_data.radius);
                  color_ff <= req_data.color;
                  rsp_ff   <= '0;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               disc_ff <= cmd_ff == CMD_DISC;
               case (cmd_ff)
                  CMD_FILL: state_ff <= ST_FILL_N;
                  CMD_RECT: begin
                     bx_lo_ff <= smax(px_ff, '0);
                     bx_hi_ff <= rect_xe;
                     by_lo_ff <= smax(py_ff, '0);
                     by_hi_ff <= rect_ye;
                     state_ff <= ST_BOX_CHK;
                  end
                  CMD_DISC: begin
                     bx_lo_ff <= dsc_xl;
                     bx_hi_ff <= dsc_xh;
                     by_lo_ff <= dsc_yl;
                     by_hi_ff <= dsc_yh;
                     state_ff <= (rad_ff < 0) ? ST_DONE : ST_BOX_CHK;
                  end
                  CMD_LINE: begin
                     ldx_ff   <= px_ff - ex_ff;
                     ldy_ff   <= py_ff - ey_ff;
                     bx_lo_ff <= ln_lo;
                     bx_hi_ff <= ln_hi;
                     state_ff <= ST_LINE_M0;
                  end
                  CMD_READ: state_ff <= ST_READ_ADDR;
                  default:  state_ff <= ST_DONE;
               endcase
            end
            // whole canvas, linear addresses
            ST_FILL_N: begin
               n_ff     <= (AW+1)'(mul_p);
               addr_ff  <= '0;
               state_ff <= ST_FILL;
            end
            ST_FILL: begin
               if ((n_ff == '0) || ({1'b0, addr_ff} == n_ff - 1'b1)) begin
                  state_ff <= ST_DONE;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            // rectangle and disc share the box walk
            ST_BOX_CHK: begin
               dx_ff <= bx_lo_ff - px_ff;
               dy_ff <= by_lo_ff - py_ff;
               x_ff  <= bx_lo_ff;
               y_ff  <= by_lo_ff;
               if ((bx_lo_ff > bx_hi_ff) || (by_lo_ff > by_hi_ff)) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= disc_ff ? ST_BOX_R2 : ST_BOX_ADDR;
               end
            end
            ST_BOX_R2: begin
               r2_ff    <= SQ_W'(mul_p);
               state_ff <= ST_BOX_DX;
            end
            ST_BOX_DX: begin
               dxs2_ff  <= SQ_W'(mul_p);
               dx2_ff   <= SQ_W'(mul_p);
               state_ff <= ST_BOX_DY;
            end
            ST_BOX_DY: begin
               dy2_ff   <= SQ_W'(mul_p);
               state_ff <= ST_BOX_ADDR;
            end
            ST_BOX_ADDR: begin
               row_ff   <= AW'(mul_p);
               addr_ff  <= AW'(mul_p + PROD_W'(bx_lo_ff));
               state_ff <= ST_BOX;
            end
            ST_BOX: begin
               if (x_ff == bx_hi_ff) begin
                  if (y_ff == by_hi_ff) begin
                     state_ff <= ST_DONE;
                  end else begin
                     y_ff    <= y_ff + CRD_W'(1);
                     x_ff    <= bx_lo_ff;
                     row_ff  <= row_ff + AW'(ew);
                     addr_ff <= row_ff + AW'(ew) + AW'(bx_lo_ff);
                     dx_ff   <= bx_lo_ff - px_ff;
                     dx2_ff  <= dxs2_ff;
                     dy_ff   <= dy_ff + CRD_W'(1);
                     dy2_ff  <= dy2_nx;
                  end
               end else begin
                  x_ff    <= x_ff + CRD_W'(1);
                  addr_ff <= addr_ff + 1'b1;
                  dx_ff   <= dx_ff + CRD_W'(1);
                  dx2_ff  <= dx2_nx;
               end
            end
            // line: offset divide, then one divide per column edge; a vertical line goes to its span
            ST_LINE_M0: begin
               if (ldx_ff == '0) begin
                  sp_x_ff    <= px_ff;
                  ya_ff      <= LY_W'(py_ff);
                  yb_ff      <= LY_W'(ey_ff);
                  sp_line_ff <= 1'b0;
                  state_ff   <= ST_SPAN_CLIP;
               end else begin
                  prod_ff      <= mul_p;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_LINE_D0;
               end
            end
            ST_LINE_D0: begin
               if (div_done) begin
                  off_ff <= LY_W'(py_ff) - q_ly;
                  x_ff   <= bx_lo_ff;
                  state_ff <= (bx_lo_ff > bx_hi_ff) ? ST_DONE : ST_LINE_MA;
               end
            end
            ST_LINE_MA: begin
               prod_ff      <= mul_p;
               div_start_ff <= 1'b1;
               state_ff     <= ST_LINE_DA;
            end
            ST_LINE_DA: begin
               if (div_done) begin
                  qa_ff    <= q_ly;
                  state_ff <= ST_LINE_MB;
               end
            end
            ST_LINE_MB: begin
               prod_ff      <= mul_p;
               div_start_ff <= 1'b1;
               state_ff     <= ST_LINE_DB;
            end
            ST_LINE_DB: begin
               if (div_done) begin
                  ya_ff      <= qa_ff + off_ff;
                  yb_ff      <= q_ly + off_ff;
                  qa_ff      <= q_ly;
                  sp_x_ff    <= x_ff;
                  sp_line_ff <= 1'b1;
                  state_ff   <= ST_SPAN_CLIP;
               end
            end
            ST_LINE_NEXT: begin
               if (x_ff == bx_hi_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  x_ff     <= x_ff + CRD_W'(1);
                  state_ff <= ST_LINE_MB;
               end
            end
            // vertical span at one column
            ST_SPAN_CLIP: begin
               y_ff     <= (sp_lo < 0) ? '0 : CRD_W'(sp_lo);
               by_hi_ff <= (sp_hi > LY_W'(eh_s) - LY_W'(1)) ? eh_s - CRD_W'(1)
                                                            : CRD_W'(sp_hi);
               if ((sp_x_ff < 0) || (sp_x_ff >= ew_s) || (sp_hi < 0) ||
                   (sp_lo > LY_W'(eh_s) - LY_W'(1)) || (eh == '0)) begin
                  state_ff <= sp_line_ff ? ST_LINE_NEXT : ST_DONE;
               end else begin
                  state_ff <= ST_SPAN_ADDR;
               end
            end
            ST_SPAN_ADDR: begin
               addr_ff  <= AW'(mul_p + PROD_W'(sp_x_ff));
               state_ff <= ST_SPAN;
            end
            ST_SPAN: begin
               if (y_ff == by_hi_ff) begin
                  state_ff <= sp_line_ff ? ST_LINE_NEXT : ST_DONE;
               end else begin
                  y_ff    <= y_ff + CRD_W'(1);
                  addr_ff <= addr_ff + AW'(ew);
               end
            end
            // pixel read back
            ST_READ_ADDR: begin
               addr_ff <= AW'(mul_p + PROD_W'(px_ff));
               if ((px_ff >= 0) && (px_ff < ew_s) && (py_ff >= 0) && (py_ff < eh_s)) begin
                  state_ff <= ST_READ_MEM;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_READ_MEM: state_ff <= ST_READ_DATA;
            ST_READ_DATA: begin
               rsp_ff.first_byte   <= rdata_ff[7:0];
               rsp_ff.second_byte  <= rdata_ff[15:8];
               rsp_ff.third_byte   <= rdata_ff[23:16];
               rsp_ff.is_read_data <= 1'b1;
               state_ff <= ST_DONE;
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> tb/rpd_checker.sv
`timescale 1ns / 1ps

module rpd_checker
   import rpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire req_type               req_data,
   input  wire logic                  rsp_strobe,
   input  wire rsp_type               rsp_data,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending_rsp
);

   localparam int FRAME_W = 256;
   localparam int FRAME_H = 256;

   logic [23:0]              shadow_frame [0:FRAME_W*FRAME_H-1];
   logic [CSR_DATA_W-1:0]    width_reg;
   logic [CSR_DATA_W-1:0]    height_reg;
   rsp_type                  expected_rsp [$];

   function automatic longint live_w();
      return (width_reg > FRAME_W) ? FRAME_W : longint'(width_reg);
   endfunction

   function automatic longint live_h();
      return (height_reg > FRAME_H) ? FRAME_H : longint'(height_reg);
   endfunction

   function automatic longint lmin(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint lmax(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic void plot(longint x, longint y, logic [23:0] c);
      if (x >= 0 && x < live_w() && y >= 0 && y < live_h())
         shadow_frame[y * live_w() + x] = c;
   endfunction

   // clipped vertical run at one column, ends in either order
   function automatic void column_run(longint x, longint ya, longint yb, logic [23:0] c);
      longint lo;
      longint hi;
      lo = lmax(lmin(ya, yb), 0);
      hi = lmin(lmax(ya, yb), live_h() - 1);
      if (x < 0 || x >= live_w())
         return;
      for (longint y = lo; y <= hi; y++)
         plot(x, y, c);
   endfunction

   // update the shadow frame and work out the beat the engine owes
   function automatic rsp_type paint(req_type r);
      rsp_type e;
      longint  px, py, ex, ey, rw, rh, rad, xs, xe, ys, ye, dx, dy, off;
      logic [23:0] v;
      e = '0;
      px = longint'(r.point_x);
      py = longint'(r.point_y);
      ex = longint'(r.end_x);
      ey = longint'(r.end_y);
      rw = longint'(r.rect_width);
      rh = longint'(r.rect_height);
      rad = longint'(r.radius);
      case (r.command)
         CMD_FILL: begin
            for (longint i = 0; i < live_w() * live_h(); i++)
               shadow_frame[i] = r.color;
         end
         CMD_RECT: begin
            xs = lmax(px, 0);
            xe = lmin(px + rw, live_w());
            ys = lmax(py, 0);
            ye = lmin(py + rh, live_h());
            for (longint y = ys; y < ye; y++)
               for (longint x = xs; x < xe; x++)
                  plot(x, y, r.color);
         end
         CMD_DISC: begin
            if (rad >= 0) begin
               xs = lmax(px - rad, 0);
               xe = lmin(px + rad, live_w() - 1);
               ys = lmax(py - rad, 0);
               ye = lmin(py + rad, live_h() - 1);
               for (longint y = ys; y <= ye; y++)
                  for (longint x = xs; x <= xe; x++)
                     if ((x - px) * (x - px) + (y - py) * (y - py) <= rad * rad)
                        plot(x, y, r.color);
            end
         end
         CMD_LINE: begin
            dx = px - ex;
            dy = py - ey;
            if (dx != 0) begin
               // slope spans; SV division truncates toward zero like C
               off = py - (dy * px) / dx;
               xs = lmax(lmin(px, ex), 0);
               xe = lmin(lmax(px, ex), live_w() - 1);
               for (longint x = xs; x <= xe; x++)
                  column_run(x, (dy * x) / dx + off, (dy * (x + 1)) / dx + off, r.color);
            end else begin
               column_run(px, py, ey, r.color);
            end
         end
         CMD_READ: begin
            if (px >= 0 && px < live_w() && py >= 0 && py < live_h()) begin
               v = shadow_frame[py * live_w() + px];
               e.first_byte = v[7:0];
               e.second_byte = v[15:8];
               e.third_byte = v[23:16];
               e.is_read_data = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return e;
   endfunction

   assign pending_rsp = expected_rsp.size();

   // track registers, predict on each command beat, compare each result beat
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         width_reg <= CSR_SIZE_RESET;
         height_reg <= CSR_SIZE_RESET;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected result beat %h", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.first_byte !== want.first_byte ||
                   rsp_data.second_byte !== want.second_byte ||
                   rsp_data.third_byte !== want.third_byte ||
                   rsp_data.is_read_data !== want.is_read_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("result mismatch: expected %h %h %h %b, got %h %h %h %b",
                              want.first_byte, want.second_byte, want.third_byte,
                              want.is_read_data, rsp_data.first_byte,
                              rsp_data.second_byte, rsp_data.third_byte,
                              rsp_data.is_read_data);
               end
            end
         end
         if (start && !busy)
            expected_rsp.push_back(paint(req_data));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CANVAS_WIDTH)
               width_reg <= csr_data;
            else if (csr_index == CSR_CANVAS_HEIGHT)
               height_reg <= csr_data;
         end
      end
   end

endmodule

>>> tb/tb_raster_primitive_drawer_top.sv
`timescale 1ns / 1ps

module tb_raster_primitive_drawer_top;
   import rpd_pkg::*;

   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int STALL_LIMIT = 400000;
   localparam int PHASES = 13;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending_rsp;
   int                    quiet_cycles;
   int                    cur_w;
   int                    cur_h;
   bit                    canvas_filled;
   bit                    allow_idle;

   raster_primitive_drawer_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   rpd_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_rsp(pending_rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // hold the command until the engine takes it, then maybe drop start a while
   task automatic send_beat(input req_type r);
      int gap;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (allow_idle && $urandom_range(0, 99) < 35) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drain all results, then resize the canvas
   task automatic resize(input int w, input int h);
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      write_reg(CSR_CANVAS_WIDTH, w);
      write_reg(CSR_CANVAS_HEIGHT, h);
      cur_w = (w > 256) ? 256 : w;
      cur_h = (h > 256) ? 256 : h;
      canvas_filled = 1'b0;
   endtask

   function automatic logic [FLD_W-1:0] pick_coord(int span);
      if ($urandom_range(0, 99) < 20)
         return FLD_W'($urandom());
      return FLD_W'($urandom_range(0, span + 8) - 4);
   endfunction

   function automatic req_type make_beat(logic [2:0] cmd);
      req_type r;
      r = '0;
      r.command = cmd;
      r.color = 24'($urandom());
      r.point_x = pick_coord(cur_w);
      r.point_y = pick_coord(cur_h);
      r.end_x = pick_coord(cur_w);
      r.end_y = pick_coord(cur_h);
      r.rect_width = ($urandom_range(0, 9) < 7) ? FLD_W'($urandom_range(0, cur_w + 2))
                                                : FLD_W'($urandom());
      r.rect_height = ($urandom_range(0, 9) < 7) ? FLD_W'($urandom_range(0, cur_h + 2))
                                                 : FLD_W'($urandom());
      case ($urandom_range(0, 9))
         0: r.radius = FLD_W'(-$urandom_range(1, 2048));
         1: r.radius = FLD_W'($urandom());
         default: r.radius = FLD_W'($urandom_range(0, cur_w / 2 + 2));
      endcase
      if (cmd == CMD_READ) begin
         r.point_x = FLD_W'($urandom_range(0, cur_w + 3) - 2);
         r.point_y = FLD_W'($urandom_range(0, cur_h + 3) - 2);
      end
      return r;
   endfunction

   function automatic req_type directed(logic [2:0] cmd, int px, int py, int ex, int ey,
                                        int rw, int rh, int rad, logic [23:0] c);
      req_type r;
      r.command = cmd;
      r.point_x = FLD_W'(px);
      r.point_y = FLD_W'(py);
      r.end_x = FLD_W'(ex);
      r.end_y = FLD_W'(ey);
      r.rect_width = FLD_W'(rw);
      r.rect_height = FLD_W'(rh);
      r.radius = FLD_W'(rad);
      r.color = c;
      return r;
   endfunction

   task automatic random_phase(int count);
      int pick;
      logic [2:0] cmd;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (!canvas_filled || pick < 5) cmd = CMD_FILL;
         else if (pick < 25) cmd = CMD_RECT;
         else if (pick < 45) cmd = CMD_DISC;
         else if (pick < 65) cmd = CMD_LINE;
         else if (pick < 95) cmd = CMD_READ;
         else cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
         send_beat(make_beat(cmd));
         if (cmd == CMD_FILL) canvas_filled = 1'b1;
      end
   endtask

   initial begin
      int sizes_w [PHASES];
      int sizes_h [PHASES];
      sizes_w = '{1, 256, 1, 0, 7, 511, 3, 16, 0, 0, 0, 0, 0};
      sizes_h = '{1, 1, 256, 7, 0, 2, 300, 16, 0, 0, 0, 0, 0};
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CANVAS_WIDTH;
      csr_data = '0;
      cur_w = 256;
      cur_h = 256;
      canvas_filled = 1'b0;
      allow_idle = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at the reset canvas size
      send_beat(directed(CMD_FILL, 0, 0, 0, 0, 0, 0, 0, 24'hA5C3E1));
      send_beat(directed(CMD_READ, 255, 255, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_READ, 256, 0, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_READ, -1, 3, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_READ, -2048, 2047, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_RECT, -2048, -2048, 0, 0, 4095, 4095, 0, 24'hFFFFFF));
      send_beat(directed(CMD_RECT, 10, 10, 0, 0, 0, 5, 0, 24'h123456));
      send_beat(directed(CMD_RECT, 2047, 2047, 0, 0, 4095, 0, 0, 24'h000000));
      send_beat(directed(CMD_RECT, 20, 30, 0, 0, 7, 3, 0, 24'h00FF00));
      send_beat(directed(CMD_READ, 26, 32, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_DISC, 100, 100, 0, 0, 0, 0, -1, 24'h0000FF));
      send_beat(directed(CMD_DISC, 100, 100, 0, 0, 0, 0, -2048, 24'h0000FF));
      send_beat(directed(CMD_DISC, 50, 60, 0, 0, 0, 0, 0, 24'h800001));
      send_beat(directed(CMD_DISC, 5, 5, 0, 0, 0, 0, 9, 24'h7F7F7F));
      send_beat(directed(CMD_READ, 5, 14, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_LINE, 40, 10, 40, 200, 0, 0, 0, 24'hC0FFEE));
      send_beat(directed(CMD_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 24'h0F0F0F));
      send_beat(directed(CMD_LINE, 200, 3, 10, 90, 0, 0, 0, 24'hF0F0F0));
      send_beat(directed(CMD_READ, 40, 100, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_READ, 100, 100, 0, 0, 0, 0, 0, 24'h0));
      send_beat(directed(CMD_SPARE_LO, 1, 1, 1, 1, 1, 1, 1, 24'hFFFFFF));
      send_beat(directed(CMD_SPARE_HI, 1, 1, 1, 1, 1, 1, 1, 24'hFFFFFF));

      // random phases over edge and random canvas sizes
      for (int p = 0; p < PHASES; p++) begin
         if (p >= 8) begin
            sizes_w[p] = $urandom_range(1, 40);
            sizes_h[p] = $urandom_range(1, 40);
         end
         resize(sizes_w[p], sizes_h[p]);
         allow_idle = (p != 9);
         random_phase(44);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_rsp == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
